// File: rtl/core/bbvp_pkg.sv
// ----------------------------------------------------------------------------
// Basic block vector profiler package
// Shared constants, codes and the types that pass between controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package bbvp_pkg;

  // Table size and the widths that follow from it.
  localparam int NUM_BLOCKS = 32;
  localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  // Fixed field widths of the request and record channels.
  localparam int OPC_W   = 2;
  localparam int ID_W    = 5;
  localparam int ICNT_W  = 16;
  localparam int THR_W   = 40;
  localparam int CNT_W   = 48;
  localparam int HITS_W  = 32;
  localparam int RNUM_W  = 32;

  // Request opcodes; the fourth code is unused and ignored.
  typedef enum logic [OPC_W-1:0] {
    OP_BLOCK = 2'd0,
    OP_BEGIN = 2'd1,
    OP_END   = 2'd2
  } opcode_t;

  // Record kinds.
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  // Threshold after reset.
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(100000000);

  // One result record.
  typedef struct packed {
    logic              record_kind;
    logic [RNUM_W-1:0] region_index;
    logic [CNT_W-1:0]  region_instructions;
    logic [CNT_W-1:0]  total_instructions;
    logic [ID_W-1:0]   entry_block;
    logic [HITS_W-1:0] block_hits;
    logic [CNT_W-1:0]  block_stamp;
    logic              last;
  } record_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic roi_set;   // begin of the region of interest
    logic roi_clr;   // end of the region of interest
    logic ev_start;  // latch a block event and read its table entry
    logic upd;       // write back the updated entry and region count
    logic hdr_load;  // load the region header into the output register
    logic ent_rd;    // read the lowest pending table entry
    logic ent_load;  // load that entry into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic roi_active;    // region of interest is open
    logic in_range;      // block index of the request is within the table
    logic over_thr;      // updated region count exceeds the threshold
    logic pending_any;   // table still holds entries to dump
    logic pending_rest;  // entries remain besides the one being sent
    logic out_free;      // output register can take a record this cycle
  } dp_status_t;

endpackage

// File: rtl/core/bbvp_in_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one profiling request.
// ----------------------------------------------------------------------------
interface bbvp_in_if
  import bbvp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OPC_W-1:0]  opcode;
  logic [ID_W-1:0]   block_id;
  logic [ICNT_W-1:0] instruction_count;

  modport source (output valid, output opcode, output block_id,
                  output instruction_count, input ready);
  modport sink   (input valid, input opcode, input block_id,
                  input instruction_count, output ready);
endinterface

// File: rtl/core/bbvp_out_if.sv
// ----------------------------------------------------------------------------
// Record channel
// Valid/ready channel that carries one region header or block entry record.
// ----------------------------------------------------------------------------
interface bbvp_out_if
  import bbvp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              record_kind;
  logic [RNUM_W-1:0] region_index;
  logic [CNT_W-1:0]  region_instructions;
  logic [CNT_W-1:0]  total_instructions;
  logic [ID_W-1:0]   entry_block;
  logic [HITS_W-1:0] block_hits;
  logic [CNT_W-1:0]  block_stamp;
  logic              last;

  modport source (output valid, output record_kind, output region_index,
                  output region_instructions, output total_instructions,
                  output entry_block, output block_hits, output block_stamp,
                  output last, input ready);
  modport sink   (input valid, input record_kind, input region_index,
                  input region_instructions, input total_instructions,
                  input entry_block, input block_hits, input block_stamp,
                  input last, output ready);
endinterface

// File: rtl/core/bbvp_ctrl.sv
// ----------------------------------------------------------------------------
// Profiler controller
// Sequences request decode, table update and the region dump.
// ----------------------------------------------------------------------------
module bbvp_ctrl
  import bbvp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [OPC_W-1:0] opcode,
  input  dp_status_t       status,
  output ctrl_cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_HDR,
    S_ENT_RD,
    S_ENT_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (opcode_t'(opcode))
            OP_BEGIN: begin
              cmd.roi_set = 1'b1;
            end
            OP_END: begin
              if (status.roi_active) begin
                cmd.roi_clr = 1'b1;
                state_next  = S_HDR;
              end
            end
            OP_BLOCK: begin
              if (status.roi_active && status.in_range) begin
                cmd.ev_start = 1'b1;
                state_next   = S_UPD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = status.over_thr ? S_HDR : S_IDLE;
      end
      S_HDR: begin
        if (status.out_free) begin
          cmd.hdr_load = 1'b1;
          state_next   = status.pending_any ? S_ENT_RD : S_IDLE;
        end
      end
      S_ENT_RD: begin
        cmd.ent_rd = 1'b1;
        state_next = S_ENT_OUT;
      end
      S_ENT_OUT: begin
        if (status.out_free) begin
          cmd.ent_load = 1'b1;
          state_next   = status.pending_rest ? S_ENT_RD : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/core/bbvp_dpath.sv
// ----------------------------------------------------------------------------
// Profiler datapath
// Region counters, the hit and stamp table, and the output record register.
// ----------------------------------------------------------------------------
module bbvp_dpath
  import bbvp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [THR_W-1:0]  cfg_wr_data,
  input  logic [ID_W-1:0]   block_id,
  input  logic [ICNT_W-1:0] instruction_count,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        status,
  output logic              rec_valid,
  input  logic              rec_ready,
  output record_t           rec
);

  localparam int ENT_W = HITS_W + CNT_W;

  // Architectural state.
  logic [THR_W-1:0]      threshold;
  logic                  roi_active;
  logic [CNT_W-1:0]      region_count;
  logic [CNT_W-1:0]      grand_total;
  logic [RNUM_W-1:0]     region_number;
  logic [NUM_BLOCKS-1:0] valid_bits;

  // Table memory: hit count in the upper part, stamp in the lower part.
  logic [ENT_W-1:0]      table_mem [NUM_BLOCKS];
  logic [ENT_W-1:0]      rd_data;
  logic [BLK_W-1:0]      rd_addr;
  logic                  rd_en;

  // Latched event and dump index.
  logic [BLK_W-1:0]      blk_q;
  logic [ICNT_W-1:0]     cnt_q;
  logic [BLK_W-1:0]      ent_idx;

  // Update arithmetic.
  logic [CNT_W:0]        count_sum;
  logic [CNT_W-1:0]      count_new;
  logic [HITS_W-1:0]     hits_old;
  logic [HITS_W-1:0]     hits_new;
  logic [CNT_W:0]        total_sum;
  logic [CNT_W-1:0]      total_new;
  logic [RNUM_W-1:0]     number_new;

  // Pending entry search.
  logic [NUM_BLOCKS-1:0] first_hot;
  logic [BLK_W-1:0]      first_idx;
  logic [NUM_BLOCKS-1:0] pending_after;

  // Record to be loaded into the output register.
  record_t               rec_load;

  // The saturating region count and hit count of the event being updated.
  assign count_sum = {1'b0, region_count} + {{(CNT_W - ICNT_W + 1){1'b0}}, cnt_q};
  assign count_new = count_sum[CNT_W] ? {CNT_W{1'b1}} : count_sum[CNT_W-1:0];
  assign hits_old  = valid_bits[blk_q] ? rd_data[ENT_W-1:CNT_W] : '0;
  assign hits_new  = (hits_old == {HITS_W{1'b1}}) ? hits_old : hits_old + 1'b1;

  // Running total including the region being closed.
  assign total_sum = {1'b0, grand_total} + {1'b0, region_count};
  assign total_new = total_sum[CNT_W] ? {CNT_W{1'b1}} : total_sum[CNT_W-1:0];

  assign number_new = (region_number == {RNUM_W{1'b1}}) ? region_number
                                                         : region_number + 1'b1;

  // Lowest entry still to be dumped, as a one-hot word and as an index.
  assign first_hot = valid_bits & (~valid_bits + 1'b1);
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      if (first_hot[i]) begin
        first_idx = first_idx | BLK_W'(i);
      end
    end
  end

  // Entries left once the current one has been sent.
  assign pending_after = valid_bits & ~(NUM_BLOCKS'(1) << ent_idx);

  // Status towards the controller.
  always_comb begin
    status              = '0;
    status.roi_active   = roi_active;
    status.in_range     = ({1'b0, block_id} < (ID_W + 1)'(NUM_BLOCKS));
    status.over_thr     = (count_new > {{(CNT_W - THR_W){1'b0}}, threshold});
    status.pending_any  = (valid_bits != '0);
    status.pending_rest = (pending_after != '0);
    status.out_free     = !rec_valid || rec_ready;
  end

  // Table read address: the event's block or the next entry to dump.
  assign rd_en   = cmd.ev_start || cmd.ent_rd;
  assign rd_addr = cmd.ev_start ? BLK_W'(block_id) : first_idx;

  // Table memory with registered read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= table_mem[rd_addr];
    end
    if (cmd.upd) begin
      table_mem[blk_q] <= {hits_new, count_new};
    end
  end

  // Event and dump index latches.
  always_ff @(posedge clk) begin
    if (cmd.ev_start) begin
      blk_q <= BLK_W'(block_id);
      cnt_q <= instruction_count;
    end
    if (cmd.ent_rd) begin
      ent_idx <= first_idx;
    end
  end

  // Configuration and region state.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= THR_RESET;
      roi_active    <= 1'b0;
      region_count  <= '0;
      grand_total   <= '0;
      region_number <= '0;
      valid_bits    <= '0;
    end else begin
      if (cfg_wr_en) begin
        threshold <= cfg_wr_data;
      end
      if (cmd.roi_set) begin
        roi_active <= 1'b1;
      end
      if (cmd.roi_clr) begin
        roi_active <= 1'b0;
      end
      if (cmd.upd) begin
        region_count      <= count_new;
        valid_bits[blk_q] <= 1'b1;
      end
      if (cmd.hdr_load) begin
        grand_total  <= total_new;
        region_count <= '0;
        if (valid_bits == '0) begin
          region_number <= number_new;
        end
      end
      if (cmd.ent_load) begin
        valid_bits <= pending_after;
        if (pending_after == '0) begin
          region_number <= number_new;
        end
      end
    end
  end

  // Output record valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (cmd.hdr_load || cmd.ent_load) begin
      rec_valid <= 1'b1;
    end else if (rec_ready) begin
      rec_valid <= 1'b0;
    end
  end

  // Header or entry record, with every field it does not use at zero.
  always_comb begin
    rec_load              = '0;
    rec_load.region_index = region_number;
    if (cmd.ent_load) begin
      rec_load.record_kind = KIND_ENTRY;
      rec_load.entry_block = ID_W'(ent_idx);
      rec_load.block_hits  = rd_data[ENT_W-1:CNT_W];
      rec_load.block_stamp = rd_data[CNT_W-1:0];
      rec_load.last        = (pending_after == '0);
    end else begin
      rec_load.record_kind         = KIND_HEADER;
      rec_load.region_instructions = region_count;
      rec_load.total_instructions  = total_new;
      rec_load.last                = (valid_bits == '0);
    end
  end

  // Output record payload.
  always_ff @(posedge clk) begin
    if (cmd.hdr_load || cmd.ent_load) begin
      rec <= rec_load;
    end
  end

endmodule

// File: rtl/core/basic_block_vector_profiler.sv
// ----------------------------------------------------------------------------
// Basic block vector profiler
// Counts basic block executions per region of interest and dumps each
// closed region as a header followed by its nonzero block entries.
// ----------------------------------------------------------------------------
// A begin request, an end request or a block event that is ignored needs no
// table access. A counted block event reads its table entry and then writes it
// back in the update state, because the table is a single memory with a
// registered read. Closing a region loads the header and then reads each
// nonzero entry and loads it into the output register, and it stalls while
// the record consumer holds ready low; no request is taken while a dump runs.
// The table is cleared at reset and after every dump through per-entry valid
// flags, so no clearing pass is needed.
module basic_block_vector_profiler
  import bbvp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [THR_W-1:0] cfg_wr_data,
  bbvp_in_if.sink          sample,
  bbvp_out_if.source       record
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  record_t    rec;
  logic       rec_valid;

  // Controller.
  bbvp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .opcode   (sample.opcode),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  bbvp_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .block_id          (sample.block_id),
    .instruction_count (sample.instruction_count),
    .cmd               (cmd),
    .status            (status),
    .rec_valid         (rec_valid),
    .rec_ready         (record.ready),
    .rec               (rec)
  );

  // Record channel.
  assign record.valid               = rec_valid;
  assign record.record_kind         = rec.record_kind;
  assign record.region_index        = rec.region_index;
  assign record.region_instructions = rec.region_instructions;
  assign record.total_instructions  = rec.total_instructions;
  assign record.entry_block         = rec.entry_block;
  assign record.block_hits          = rec.block_hits;
  assign record.block_stamp         = rec.block_stamp;
  assign record.last                = rec.last;

  // A record is only loaded when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.hdr_load || cmd.ent_load) |-> status.out_free)
    else $error("record loaded while output register is occupied");

  // A latched block event is always written back in the following cycle.
  a_ev_upd: assert property (@(posedge clk) disable iff (rst)
    cmd.ev_start |=> cmd.upd)
    else $error("block event not written back");

  // Datapath operations never overlap.
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.ev_start, cmd.upd, cmd.hdr_load, cmd.ent_rd, cmd.ent_load}))
    else $error("overlapping datapath commands");

  // An entry read is only issued while entries remain to be dumped.
  a_rd_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.ent_rd |-> status.pending_any)
    else $error("entry read with empty table");

endmodule

// File: tb/sv/basic_block_vector_profiler_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Basic block vector profiler test
// Sends profiling requests (block events, region of interest begin and end)
// in random bursts. A behavioural profile of the block works out the region
// dumps that each request should cause. Every record from the block is
// checked field by field against that profile while the record side stalls
// on a rotating pattern. The region threshold is changed between phases,
// once the block has gone quiet.
// ----------------------------------------------------------------------------
module basic_block_vector_profiler_test;
  import bbvp_pkg::*;

  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  // One profiling request as it goes over the sample channel.
  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [ID_W-1:0]   block_id;
    logic [ICNT_W-1:0] icount;
  } request_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wr_en;
  logic [THR_W-1:0] cfg_wr_data;

  bbvp_in_if  sample_if ();
  bbvp_out_if record_if ();

  basic_block_vector_profiler i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sample      (sample_if),
    .record      (record_if)
  );

  // Requests waiting to be sent and records the block still owes.
  request_t request_backlog[$];
  record_t  region_records[$];
  request_t in_flight;
  int       queued_total   = 0;
  int       accepted_total = 0;
  int       error_count    = 0;
  int       burst_left     = 0;
  int       gap_left       = 0;
  int       pattern_age    = 0;
  int       idle_cycles    = 0;
  logic [7:0] ready_pattern;

  // Profile state kept alongside the block.
  logic [THR_W-1:0]  threshold_now;
  logic              roi_on;
  logic [CNT_W-1:0]  region_icount;
  logic [CNT_W-1:0]  total_icount;
  logic [RNUM_W-1:0] region_num;
  logic [HITS_W-1:0] hit_tab[NUM_BLOCKS];
  logic [CNT_W-1:0]  stamp_tab[NUM_BLOCKS];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [CNT_W-1:0] add_clamped(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

  // Close the current region: header, then every block hit in the region in
  // ascending order, the final record flagged as last. Then clear the tables.
  function automatic void dump_region();
    record_t rec;
    int      top;
    top = -1;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      if (hit_tab[i] != '0) top = i;
    end
    total_icount = add_clamped(total_icount, region_icount);
    rec = '0;
    rec.record_kind         = KIND_HEADER;
    rec.region_index        = region_num;
    rec.region_instructions = region_icount;
    rec.total_instructions  = total_icount;
    rec.last                = (top < 0);
    region_records.push_back(rec);
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      if (hit_tab[i] != '0) begin
        rec = '0;
        rec.record_kind  = KIND_ENTRY;
        rec.region_index = region_num;
        rec.entry_block  = ID_W'(i);
        rec.block_hits   = hit_tab[i];
        rec.block_stamp  = stamp_tab[i];
        rec.last         = (i == top);
        region_records.push_back(rec);
      end
    end
    if (region_num != {RNUM_W{1'b1}}) region_num++;
    region_icount = '0;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      hit_tab[i]   = '0;
      stamp_tab[i] = '0;
    end
  endfunction

  // Apply one accepted request to the profile.
  function automatic void profile_request(request_t req);
    case (req.opcode)
      OP_BEGIN: roi_on = 1'b1;
      OP_END: begin
        if (roi_on) begin
          roi_on = 1'b0;
          dump_region();
        end
      end
      OP_BLOCK: begin
        if (roi_on && req.block_id < NUM_BLOCKS) begin
          region_icount = add_clamped(region_icount, CNT_W'(req.icount));
          if (hit_tab[req.block_id] != {HITS_W{1'b1}}) hit_tab[req.block_id]++;
          stamp_tab[req.block_id] = region_icount;
          if (region_icount > CNT_W'(threshold_now)) dump_region();
        end
      end
      default: ;
    endcase
  endfunction

  task automatic push_req(input logic [OPC_W-1:0] opc, input logic [ID_W-1:0] id,
                          input logic [ICNT_W-1:0] cnt);
    request_backlog.push_back('{opcode: opc, block_id: id, icount: cnt});
    queued_total++;
  endtask

  // Mostly well-formed regions with random content; the rest is noise such as
  // the unused opcode, stray ends and block events outside the region.
  task automatic add_random(input int amount);
    int counted;
    int n_events;
    logic [ICNT_W-1:0] cnt;
    logic [ID_W-1:0]   id;
    counted = 0;
    while (counted < amount) begin
      if ($urandom_range(0, 9) < 8) begin
        push_req(OP_BEGIN, ID_W'($urandom), ICNT_W'($urandom));
        counted++;
        n_events = $urandom_range(0, 24);
        repeat (n_events) begin
          case ($urandom_range(0, 7))
            0:       cnt = '0;
            1:       cnt = '1;
            default: cnt = ICNT_W'($urandom);
          endcase
          // Half the events fall on a few hot blocks so that hits build up.
          id = $urandom_range(0, 1) ? ID_W'($urandom_range(0, 3))
                                    : ID_W'($urandom_range(0, NUM_BLOCKS - 1));
          push_req(OP_BLOCK, id, cnt);
          counted++;
        end
        if ($urandom_range(0, 3) != 0) begin
          push_req(OP_END, ID_W'($urandom), ICNT_W'($urandom));
          counted++;
        end
      end else begin
        push_req(OPC_W'($urandom_range(0, 3)), ID_W'($urandom), ICNT_W'($urandom));
      end
    end
  endtask

  // Wait until every request is taken and every record is back, then let any
  // block event still in the pipeline finish.
  task automatic wait_quiet();
    while (accepted_total != queued_total || region_records.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    @(posedge clk);
    cfg_wr_en     <= 1'b1;
    cfg_wr_data   <= value;
    threshold_now  = value;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
  endtask

  task automatic check_field(input string fname, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      error_count++;
    end
  endtask

  // Request driver: bursts of random length with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      sample_if.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (sample_if.valid && sample_if.ready) begin
        profile_request(in_flight);
        accepted_total++;
      end
      if (!sample_if.valid || sample_if.ready) begin
        if (gap_left > 0 || request_backlog.size() == 0) begin
          if (gap_left > 0) gap_left--;
          sample_if.valid <= 1'b0;
        end else begin
          in_flight = request_backlog.pop_front();
          sample_if.valid             <= 1'b1;
          sample_if.opcode            <= in_flight.opcode;
          sample_if.block_id          <= in_flight.block_id;
          sample_if.instruction_count <= in_flight.icount;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Record monitor: checks each record and stalls on a rotating pattern that
  // is reloaded now and then, sometimes with no stalls at all.
  always @(posedge clk) begin
    if (rst) begin
      record_if.ready <= 1'b0;
      ready_pattern   <= 8'hFF;
      pattern_age      = 0;
    end else begin
      if (record_if.valid && record_if.ready) begin
        if (region_records.size() == 0) begin
          $display("%0t: record with nothing expected, actual kind %0h region %0h block %0h",
                   $time, record_if.record_kind, record_if.region_index,
                   record_if.entry_block);
          error_count++;
        end else begin
          record_t want;
          want = region_records.pop_front();
          check_field("record_kind", CNT_W'(want.record_kind), CNT_W'(record_if.record_kind));
          check_field("region_index", CNT_W'(want.region_index),
                      CNT_W'(record_if.region_index));
          check_field("region_instructions", want.region_instructions,
                      record_if.region_instructions);
          check_field("total_instructions", want.total_instructions,
                      record_if.total_instructions);
          check_field("entry_block", CNT_W'(want.entry_block), CNT_W'(record_if.entry_block));
          check_field("block_hits", CNT_W'(want.block_hits), CNT_W'(record_if.block_hits));
          check_field("block_stamp", want.block_stamp, record_if.block_stamp);
          check_field("last", CNT_W'(want.last), CNT_W'(record_if.last));
        end
      end
      record_if.ready <= ready_pattern[0];
      pattern_age++;
      if (pattern_age == 48) begin
        pattern_age = 0;
        ready_pattern <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end else begin
        ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
      end
    end
  end

  // Watchdog on cycles in which no request and no record is accepted.
  always @(posedge clk) begin
    if (rst || cfg_wr_en || (sample_if.valid && sample_if.ready) ||
        (record_if.valid && record_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("basic_block_vector_profiler verification failed");
        $finish;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    sample_if.valid             = 1'b0;
    sample_if.opcode            = OP_BLOCK;
    sample_if.block_id          = '0;
    sample_if.instruction_count = '0;
    record_if.ready             = 1'b0;
    threshold_now = THR_RESET;
    roi_on        = 1'b0;
    region_icount = '0;
    total_icount  = '0;
    region_num    = '0;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      hit_tab[i]   = '0;
      stamp_tab[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Requests outside the region, a doubled begin, an empty region, then a
    // region with field extremes, the unused opcode and a stray end.
    push_req(OP_END, 5'd0, 16'd0);
    push_req(OP_BLOCK, 5'd7, 16'd100);
    push_req(OP_UNUSED, 5'd31, 16'hFFFF);
    push_req(OP_BEGIN, 5'd0, 16'd0);
    push_req(OP_BEGIN, 5'd0, 16'd0);
    push_req(OP_END, 5'd0, 16'd0);
    push_req(OP_BEGIN, 5'd0, 16'd0);
    push_req(OP_BLOCK, 5'd0, 16'd0);
    push_req(OP_BLOCK, 5'd31, 16'hFFFF);
    push_req(OP_BLOCK, 5'd31, 16'd1);
    push_req(OP_BLOCK, 5'd21, 16'hAAAA);
    push_req(OP_BLOCK, 5'd10, 16'h5555);
    push_req(OP_UNUSED, 5'd10, 16'h5555);
    push_req(OP_BLOCK, 5'd0, 16'd0);
    push_req(OP_END, 5'd0, 16'd0);
    push_req(OP_END, 5'd0, 16'd0);
    wait_quiet();

    // Zero threshold: an empty event does not close, any counted one does.
    write_threshold('0);
    push_req(OP_BEGIN, 5'd0, 16'd0);
    push_req(OP_BLOCK, 5'd3, 16'd0);
    push_req(OP_BLOCK, 5'd3, 16'd1);
    push_req(OP_BLOCK, 5'd30, 16'hFFFF);
    push_req(OP_END, 5'd0, 16'd0);
    add_random(60);
    wait_quiet();

    // Largest threshold: regions close on end only.
    write_threshold('1);
    add_random(70);
    wait_quiet();

    write_threshold(THR_W'(150000));
    add_random(90);
    wait_quiet();

    write_threshold(THR_W'(40000));
    add_random(90);
    wait_quiet();

    write_threshold(THR_W'($urandom_range(1, 400000)));
    add_random(90);
    wait_quiet();

    if (error_count == 0) begin
      $display("basic_block_vector_profiler verification clean");
    end else begin
      $display("basic_block_vector_profiler verification failed");
    end
    $finish;
  end

endmodule
